/* src/dsdv_pkg.sv */
// shared types and constants for the dsdv route table update block
package dsdv_pkg;

  localparam int NODE_W   = 6;
  localparam int SEQ_W    = 32;
  localparam int PCOST_W  = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // opcodes
  localparam logic [1:0] OP_ADVERT   = 2'd0;
  localparam logic [1:0] OP_SET_LINK = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_UPDATED   = 2'd0;
  localparam logic [1:0] ST_NO_CHANGE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_READ_DONE = 2'd3;

  // register offsets
  localparam logic [PADDR_W-1:0] REG_SELF_NODE_ID = 3'd0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [NODE_W-1:0]  neighbor_id;
    logic [NODE_W-1:0]  dest_id;
    logic [SEQ_W-1:0]   seq_in;
    logic [PCOST_W-1:0] cost_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               route_valid;
    logic [NODE_W-1:0]  next_hop_out;
    logic [SEQ_W-1:0]   seq_out;
    logic [PCOST_W-1:0] cost_out;
  } rsp_t;

  // table lookups for the request in the compute stage
  typedef struct packed {
    logic dst_ok;
    logic nb_ok;
    logic dst_self;
    logic present;
    logic written;
    logic known;
  } flags_t;

  // table writes decided by the compute stage
  typedef struct packed {
    logic route_we;
    logic present_we;
    logic link_we;
  } upd_t;

endpackage

/* src/dsdv_calc.sv */
// update decision and result formatting for one request
module dsdv_calc #(
  parameter int COST_BITS = 16
) (
  input  dsdv_pkg::req_t                  req,
  input  dsdv_pkg::flags_t                flags,
  input  logic [COST_BITS-1:0]            link_cost,
  input  logic [dsdv_pkg::SEQ_W-1:0]      route_seq,
  input  logic [COST_BITS-1:0]            route_cost,
  input  logic [dsdv_pkg::NODE_W-1:0]     route_hop,
  output logic [COST_BITS-1:0]            cost_sum,
  output logic [COST_BITS-1:0]            cost_req,
  output dsdv_pkg::upd_t                  upd,
  output dsdv_pkg::rsp_t                  rsp
);

  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  logic [COST_BITS:0]            sum_wide;
  logic [dsdv_pkg::SEQ_W-1:0]    cur_seq;
  logic [COST_BITS-1:0]          cur_cost;
  logic [dsdv_pkg::NODE_W-1:0]   cur_hop;
  logic                          replace;

  // cost field taken in its low bits
  assign cost_req = COST_BITS'(req.cost_in);

  // saturating add of advertised and link cost
  assign sum_wide = {1'b0, cost_req} + {1'b0, link_cost};
  assign cost_sum = (sum_wide >= {1'b0, COST_INF}) ? COST_INF : sum_wide[COST_BITS-1:0];

  // a route never written reads as zero
  assign cur_seq  = flags.written ? route_seq  : '0;
  assign cur_cost = flags.written ? route_cost : '0;
  assign cur_hop  = flags.written ? route_hop  : '0;

  // newer sequence, or same sequence with lower cost
  assign replace = (req.seq_in > cur_seq) || ((req.seq_in == cur_seq) && (cost_sum < cur_cost));

  // opcode decode
  always_comb begin
    upd = '0;
    rsp = '0;
    rsp.status = dsdv_pkg::ST_NO_CHANGE;
    unique case (req.opcode)
      dsdv_pkg::OP_ADVERT: begin
        if (!flags.dst_ok || flags.dst_self) begin
          rsp.status = dsdv_pkg::ST_NO_CHANGE;
        end else if (!flags.nb_ok || !flags.known) begin
          rsp.status = dsdv_pkg::ST_UNKNOWN;
        end else begin
          upd.present_we = 1'b1;
          if (replace) begin
            upd.route_we = 1'b1;
            rsp.status   = dsdv_pkg::ST_UPDATED;
          end
        end
      end
      dsdv_pkg::OP_SET_LINK: begin
        upd.link_we = flags.nb_ok;
      end
      dsdv_pkg::OP_READ: begin
        rsp.status = dsdv_pkg::ST_READ_DONE;
        if (flags.dst_ok && flags.present) begin
          rsp.route_valid  = 1'b1;
          rsp.next_hop_out = cur_hop;
          rsp.seq_out      = cur_seq + dsdv_pkg::SEQ_W'(cur_cost == COST_INF);
          rsp.cost_out     = dsdv_pkg::PCOST_W'(cur_cost);
        end
      end
      default: begin
        rsp.status = dsdv_pkg::ST_NO_CHANGE;
      end
    endcase
  end

endmodule

/* src/dsdv_route_table_update.sv */
// top level of the dsdv route table update block
//
// Destination-sequenced distance-vector route table. Each request is one
// advert entry, one link cost setting or one route read, and produces exactly
// one response. A new request can be taken every clock cycle while the response
// side keeps up; the route and link tables are read into registers at the
// accepting edge, and the compare and update run in the compute stage and land
// in the response register when it is free or being taken. While a response
// waits, one more request can sit in the compute stage, after which the input
// stalls. Back-to-back requests to the same entry see each other's writes
// through a forwarding register. The routes and link costs live in tables
// indexed by node id, each with one write and one registered read port;
// present and known flags are flip-flops that reset clears at once, so the
// block is ready right after reset with no clearing pass. self_node_id sits
// at byte offset 0 of the register port and may only be changed while the
// block is idle.
module dsdv_route_table_update #(
  parameter int NODES     = 64,
  parameter int COST_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  dsdv_pkg::req_t                    req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output dsdv_pkg::rsp_t                    rsp_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsdv_pkg::PADDR_W-1:0]      paddr,
  input  logic [dsdv_pkg::PDATA_W-1:0]      pwdata,
  output logic [dsdv_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int ID_SPACE = 1 << dsdv_pkg::NODE_W;
  localparam int DEPTH    = (NODES < ID_SPACE) ? NODES : ID_SPACE;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int RT_W     = dsdv_pkg::SEQ_W + COST_BITS + dsdv_pkg::NODE_W;
  localparam logic [10:0] NODES_L = 11'(NODES);

  // configuration
  logic [dsdv_pkg::NODE_W-1:0] self_node_id;

  // compute stage
  logic               s1_valid;
  dsdv_pkg::req_t     s1_req;
  logic               s1_adv;
  logic               req_fire;
  logic [IDX_W-1:0]   s1_dst_idx;
  logic [IDX_W-1:0]   s1_nb_idx;
  logic [IDX_W-1:0]   in_dst_idx;
  logic [IDX_W-1:0]   in_nb_idx;

  // tables
  logic [RT_W-1:0]      route_mem [DEPTH];
  logic [COST_BITS-1:0] link_mem  [DEPTH];
  logic [RT_W-1:0]      route_rdata;
  logic [COST_BITS-1:0] link_rdata;
  logic [DEPTH-1:0]     route_present;
  logic [DEPTH-1:0]     route_written;
  logic [DEPTH-1:0]     link_known;

  // forwarding of a write made at the same edge as the read
  logic                 rt_fwd_hit;
  logic [RT_W-1:0]      rt_fwd_data;
  logic                 lk_fwd_hit;
  logic [COST_BITS-1:0] lk_fwd_data;

  logic [RT_W-1:0]      route_word;
  logic [COST_BITS-1:0] link_word;
  logic [RT_W-1:0]      route_wdata;
  logic [COST_BITS-1:0] cost_sum;
  logic [COST_BITS-1:0] cost_req;
  dsdv_pkg::flags_t     flags;
  dsdv_pkg::upd_t       upd;
  dsdv_pkg::rsp_t       rsp_next;
  logic                 rt_we;
  logic                 lk_we;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dsdv_pkg::REG_SELF_NODE_ID[2])
                ? dsdv_pkg::PDATA_W'(self_node_id) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_node_id <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == dsdv_pkg::REG_SELF_NODE_ID[2]) begin
      self_node_id <= pwdata[dsdv_pkg::NODE_W-1:0];
    end
  end

  // handshake
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;
  assign req_fire  = req_valid && req_ready;

  assign in_dst_idx = req_data.dest_id[IDX_W-1:0];
  assign in_nb_idx  = req_data.neighbor_id[IDX_W-1:0];
  assign s1_dst_idx = s1_req.dest_id[IDX_W-1:0];
  assign s1_nb_idx  = s1_req.neighbor_id[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req <= req_data;
    end
  end

  // flag lookups for the request in the compute stage
  always_comb begin
    flags          = '0;
    flags.dst_ok   = {5'b0, s1_req.dest_id} < NODES_L;
    flags.nb_ok    = {5'b0, s1_req.neighbor_id} < NODES_L;
    flags.dst_self = s1_req.dest_id == self_node_id;
    flags.present  = flags.dst_ok && route_present[s1_dst_idx];
    flags.written  = flags.dst_ok && route_written[s1_dst_idx];
    flags.known    = flags.nb_ok && link_known[s1_nb_idx];
  end

  // table words with forwarding
  assign route_word = rt_fwd_hit ? rt_fwd_data : route_rdata;
  assign link_word  = lk_fwd_hit ? lk_fwd_data : link_rdata;

  dsdv_calc #(
    .COST_BITS (COST_BITS)
  ) u_calc (
    .req        (s1_req),
    .flags      (flags),
    .link_cost  (link_word),
    .route_seq  (route_word[RT_W-1 -: dsdv_pkg::SEQ_W]),
    .route_cost (route_word[dsdv_pkg::NODE_W +: COST_BITS]),
    .route_hop  (route_word[dsdv_pkg::NODE_W-1:0]),
    .cost_sum   (cost_sum),
    .cost_req   (cost_req),
    .upd        (upd),
    .rsp        (rsp_next)
  );

  assign rt_we       = s1_adv && upd.route_we;
  assign lk_we       = s1_adv && upd.link_we;
  assign route_wdata = {s1_req.seq_in, cost_sum, s1_req.neighbor_id};

  // route and link tables
  always_ff @(posedge clk) begin
    if (rt_we) begin
      route_mem[s1_dst_idx] <= route_wdata;
    end
    if (req_fire) begin
      route_rdata <= route_mem[in_dst_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[s1_nb_idx] <= cost_req;
    end
    if (req_fire) begin
      link_rdata <= link_mem[in_nb_idx];
    end
  end

  // capture a write that lands at the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rt_fwd_hit <= 1'b0;
      lk_fwd_hit <= 1'b0;
    end else if (req_fire) begin
      rt_fwd_hit <= rt_we && (s1_req.dest_id == req_data.dest_id);
      lk_fwd_hit <= lk_we && (s1_req.neighbor_id == req_data.neighbor_id);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rt_fwd_data <= route_wdata;
      lk_fwd_data <= cost_req;
    end
  end

  // present, written and known flags
  always_ff @(posedge clk) begin
    if (rst) begin
      route_present <= '0;
      route_written <= '0;
      link_known    <= '0;
    end else begin
      if (s1_adv && upd.present_we) begin
        route_present[s1_dst_idx] <= 1'b1;
      end
      if (rt_we) begin
        route_written[s1_dst_idx] <= 1'b1;
      end
      if (lk_we) begin
        link_known[s1_nb_idx] <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp_data <= rsp_next;
    end
  end

  // only a read response carries route fields
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != dsdv_pkg::ST_READ_DONE) |->
      (!rsp_data.route_valid && rsp_data.next_hop_out == '0
       && rsp_data.seq_out == '0 && rsp_data.cost_out == '0))
    else $error("route fields set on a non-read response");

  // a route write leaves the entry present and written
  assert property (@(posedge clk) disable iff (rst)
    rt_we |=> (route_present[$past(s1_dst_idx)] && route_written[$past(s1_dst_idx)]))
    else $error("route written without its flags");

  // a route is only replaced through a known neighbor
  assert property (@(posedge clk) disable iff (rst)
    rt_we |-> link_known[s1_nb_idx])
    else $error("route replaced through unknown neighbor");

  // an empty compute stage always takes a request
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> req_ready)
    else $error("request refused with empty compute stage");

endmodule
